/* rtl/gfhs_pkg.sv */
// Package for the fire grid heat spread block.
// Types, constants, state codes and distance weight tables; no dependencies.
package gfhs_pkg;

    localparam int MAX_SIDE    = 32;
    localparam int REACH       = 4;
    localparam int SIDE_W      = 5;
    localparam int CELL_AW     = 2 * SIDE_W;
    localparam int MEM_AW      = CELL_AW + 1;
    localparam int TEMP_W      = 16;
    localparam int FUEL_W      = 16;
    localparam int RATE_W      = 12;
    localparam int GRID_W      = 6;
    localparam int DTS_W       = 24;
    localparam int CAP_W       = 34;
    localparam int W_W         = 17;
    localparam int K_W         = 6;
    localparam int PROD_W      = 33;
    localparam int TERM_W      = 41;
    localparam int ACC_W       = 48;
    localparam int CNT_W       = 11;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CLR_W       = MEM_AW;

    localparam logic [TEMP_W-1:0] T_AMBIENT  = 16'd320;
    localparam logic [TEMP_W-1:0] T_SKIP     = 16'd321;
    localparam logic [TEMP_W-1:0] T_IGNITE   = 16'd2400;
    localparam logic [24:0]       T_BURN_MAX = 25'd12800;
    localparam logic [9:0]        CAP_MUL    = 10'd800;

    localparam logic signed [3:0] D_LO = 4'(-REACH);
    localparam logic signed [3:0] D_HI = 4'(REACH);

    localparam logic [CFG_W-1:0]  RST_COND_GAIN  = 16'd655;
    localparam logic [CFG_W-1:0]  RST_RAD_GAIN   = 16'd3932;
    localparam logic [CFG_W-1:0]  RST_BURN_RAMP  = 16'd2400;
    localparam logic [CFG_W-1:0]  RST_TIME_SCALE = 16'd128;
    localparam logic [GRID_W-1:0] RST_GRID_SIDE  = 6'd10;

    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_STEP   = 2'd1,
        MODE_READ   = 2'd2,
        MODE_IGNITE = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COND_GAIN  = 3'd0,
        CFG_RAD_GAIN   = 3'd1,
        CFG_BURN_RAMP  = 3'd2,
        CFG_TIME_SCALE = 3'd3,
        CFG_COLUMNS    = 3'd4,
        CFG_ROWS       = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL_OP,
        ST_STEP_CTR,
        ST_STEP_EVAL,
        ST_STEP_NBR,
        ST_STEP_DRAIN,
        ST_STEP_FIN1,
        ST_STEP_FIN2,
        ST_STEP_DONE
    } state_t;

    typedef struct packed {
        logic              burning;
        logic [FUEL_W-1:0] fuel;
        logic [TEMP_W-1:0] temp;
    } cell_t;

    typedef struct packed {
        logic              valid;
        logic              burning;
        logic [TEMP_W-1:0] tn;
        logic [TEMP_W-1:0] diff;
        logic [K_W-1:0]    k;
    } term_in_t;

    typedef struct packed {
        logic              valid;
        logic              busy;
        logic [TERM_W-1:0] cond;
        logic [TERM_W-1:0] rad;
    } term_out_t;

    // floor(sqrt(2^32 / k))
    function automatic logic [W_W-1:0] w_cond(input logic [K_W-1:0] k);
        logic [W_W-1:0] w;
        case (k)
            6'd1:    w = 17'd65536;
            6'd2:    w = 17'd46340;
            6'd4:    w = 17'd32768;
            6'd5:    w = 17'd29308;
            6'd8:    w = 17'd23170;
            6'd9:    w = 17'd21845;
            6'd10:   w = 17'd20724;
            6'd13:   w = 17'd18176;
            6'd16:   w = 17'd16384;
            6'd17:   w = 17'd15894;
            6'd18:   w = 17'd15446;
            6'd20:   w = 17'd14654;
            6'd25:   w = 17'd13107;
            6'd32:   w = 17'd11585;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

    // floor(65536 / k)
    function automatic logic [W_W-1:0] w_rad(input logic [K_W-1:0] k);
        logic [W_W-1:0] w;
        case (k)
            6'd1:    w = 17'd65536;
            6'd2:    w = 17'd32768;
            6'd4:    w = 17'd16384;
            6'd5:    w = 17'd13107;
            6'd8:    w = 17'd8192;
            6'd9:    w = 17'd7281;
            6'd10:   w = 17'd6553;
            6'd13:   w = 17'd5041;
            6'd16:   w = 17'd4096;
            6'd17:   w = 17'd3855;
            6'd18:   w = 17'd3640;
            6'd20:   w = 17'd3276;
            6'd25:   w = 17'd2621;
            6'd32:   w = 17'd2048;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

endpackage

/* rtl/gfhs_cmd_if.sv */
// Command channel of the fire grid block.
// Depends on gfhs_pkg for field widths.
interface gfhs_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     mode;
    logic [gfhs_pkg::SIDE_W-1:0]    cell_x;
    logic [gfhs_pkg::SIDE_W-1:0]    cell_y;
    logic [gfhs_pkg::TEMP_W-1:0]    temperature_value;
    logic [gfhs_pkg::FUEL_W-1:0]    fuel_value;
    logic [gfhs_pkg::RATE_W-1:0]    burn_rate_value;
    logic                           burning_value;
    logic [15:0]                    time_step;

    modport source (
        output valid, mode, cell_x, cell_y, temperature_value, fuel_value,
               burn_rate_value, burning_value, time_step,
        input  ready
    );
    modport sink (
        input  valid, mode, cell_x, cell_y, temperature_value, fuel_value,
               burn_rate_value, burning_value, time_step,
        output ready
    );
endinterface

/* rtl/gfhs_res_if.sv */
// Result channel of the fire grid block.
// Depends on gfhs_pkg for field widths.
interface gfhs_res_if;
    logic                           valid;
    logic                           ready;
    logic                           status;
    logic [gfhs_pkg::TEMP_W-1:0]    temperature_out;
    logic [gfhs_pkg::FUEL_W-1:0]    fuel_out;
    logic [gfhs_pkg::RATE_W-1:0]    burn_rate_out;
    logic                           burning_out;
    logic [gfhs_pkg::CNT_W-1:0]     burning_cells;

    modport source (
        output valid, status, temperature_out, fuel_out, burn_rate_out, burning_out,
               burning_cells,
        input  ready
    );
    modport sink (
        input  valid, status, temperature_out, fuel_out, burn_rate_out, burning_out,
               burning_cells,
        output ready
    );
endinterface

/* rtl/gfhs_term.sv */
// Neighbor heat term pipeline: conduction and radiation terms, three stages.
// Depends on gfhs_pkg for term types and weight tables.
module gfhs_term (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gfhs_pkg::term_in_t           tin,
    input  logic [gfhs_pkg::CFG_W-1:0]   cond_gain,
    input  logic [gfhs_pkg::CFG_W-1:0]   rad_gain,
    input  logic [gfhs_pkg::DTS_W-1:0]   dts,
    output gfhs_pkg::term_out_t          tout
);
    localparam int PW = gfhs_pkg::PROD_W;
    localparam int TW = gfhs_pkg::TERM_W;

    logic          s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic          s1_burn_reg, s2_burn_reg;
    logic [PW-1:0] s1_c_reg, s1_r_reg, s2_c_reg, s2_r_reg;
    logic [TW-1:0] s3_c_reg, s3_r_reg;

    logic [PW-1:0] s1_c_next, s1_r_next, s2_c_next, s2_r_next;
    logic [TW-1:0] s3_c_next, s3_r_next;
    logic [48:0]   c_gain_full, r_gain_full;
    logic [56:0]   c_dt_full, r_dt_full;

    always_comb
    begin
        s1_c_next   = PW'(tin.diff) * PW'(gfhs_pkg::w_cond(tin.k));
        s1_r_next   = PW'(tin.tn) * PW'(gfhs_pkg::w_rad(tin.k));
        c_gain_full = 49'(s1_c_reg) * 49'(cond_gain);
        r_gain_full = 49'(s1_r_reg) * 49'(rad_gain);
        s2_c_next   = c_gain_full[48:16];
        s2_r_next   = r_gain_full[48:16];
        c_dt_full   = 57'(s2_c_reg) * 57'(dts);
        r_dt_full   = 57'(s2_r_reg) * 57'(dts);
        s3_c_next   = c_dt_full[56:16];
        s3_r_next   = s2_burn_reg ? r_dt_full[56:16] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= tin.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_burn_reg <= tin.burning;
        s1_c_reg    <= s1_c_next;
        s1_r_reg    <= s1_r_next;
        s2_burn_reg <= s1_burn_reg;
        s2_c_reg    <= s2_c_next;
        s2_r_reg    <= s2_r_next;
        s3_c_reg    <= s3_c_next;
        s3_r_reg    <= s3_r_next;
    end

    assign tout.valid = s3_valid_reg;
    assign tout.busy  = s1_valid_reg | s2_valid_reg | s3_valid_reg;
    assign tout.cond  = s3_c_reg;
    assign tout.rad   = s3_r_reg;

endmodule

/* rtl/grid_fire_heat_spread_step.sv */
// Top level of the fire grid heat spread block: cell store, step sequencer, config.
// Depends on gfhs_pkg, gfhs_cmd_if, gfhs_res_if and gfhs_term.
//
//  channel  | dir | words
//  ---------+-----+--------------------------------------------------------
//  cmd      | in  | mode, cell_x, cell_y, temperature/fuel/burn rate/burning, time_step
//  res      | out | status, cell contents, burning_cells
//  cfg      | in  | cfg_write, cfg_index, cfg_data
//
// Write and out-of-grid words end in ST_IDLE, read and ignite use ST_CELL_OP. A step reads
// and evaluates each cell and ends in ST_STEP_DONE; each cell in use that is not cold and
// empty also takes 81 neighbor reads through the single cell store read port, drain, finish.
// After reset a clearing pass over all 2048 store words runs before the first word is taken.
// A word is taken only when the result register is empty or draining.
module grid_fire_heat_spread_step (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [gfhs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gfhs_pkg::CFG_W-1:0]       cfg_data,
    gfhs_cmd_if.sink                         cmd,
    gfhs_res_if.source                       res
);
    localparam int TW = gfhs_pkg::TEMP_W;
    localparam int FW = gfhs_pkg::FUEL_W;
    localparam int RW = gfhs_pkg::RATE_W;
    localparam int GW = gfhs_pkg::GRID_W;
    localparam int CA = gfhs_pkg::CELL_AW;
    localparam int MA = gfhs_pkg::MEM_AW;
    localparam int SW = gfhs_pkg::SIDE_W;

    // configuration
    logic [gfhs_pkg::CFG_W-1:0] cond_gain_reg, rad_gain_reg, burn_ramp_reg, time_scale_reg;
    logic [GW-1:0]              cols_reg, rows_reg;
    logic [GW-1:0]              cols_sat, rows_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cond_gain_reg  <= gfhs_pkg::RST_COND_GAIN;
            rad_gain_reg   <= gfhs_pkg::RST_RAD_GAIN;
            burn_ramp_reg  <= gfhs_pkg::RST_BURN_RAMP;
            time_scale_reg <= gfhs_pkg::RST_TIME_SCALE;
            cols_reg       <= gfhs_pkg::RST_GRID_SIDE;
            rows_reg       <= gfhs_pkg::RST_GRID_SIDE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gfhs_pkg::CFG_COND_GAIN:  cond_gain_reg  <= cfg_data;
                gfhs_pkg::CFG_RAD_GAIN:   rad_gain_reg   <= cfg_data;
                gfhs_pkg::CFG_BURN_RAMP:  burn_ramp_reg  <= cfg_data;
                gfhs_pkg::CFG_TIME_SCALE: time_scale_reg <= cfg_data;
                gfhs_pkg::CFG_COLUMNS:    cols_reg       <= cfg_data[GW-1:0];
                gfhs_pkg::CFG_ROWS:       rows_reg       <= cfg_data[GW-1:0];
                default: ;
            endcase
        end
    end

    assign cols_sat = (cols_reg > GW'(gfhs_pkg::MAX_SIDE)) ? GW'(gfhs_pkg::MAX_SIDE) : cols_reg;
    assign rows_sat = (rows_reg > GW'(gfhs_pkg::MAX_SIDE)) ? GW'(gfhs_pkg::MAX_SIDE) : rows_reg;

    // cell store (two banks) and burn rate store
    gfhs_pkg::cell_t cell_mem [2**MA];
    logic [RW-1:0]   rate_mem [2**CA];
    gfhs_pkg::cell_t cell_rd_reg, mem_wdata;
    logic [RW-1:0]   rate_rd_reg, rate_wdata;
    logic            mem_we, rate_we;
    logic [MA-1:0]   mem_waddr, mem_raddr;
    logic [CA-1:0]   rate_waddr, rate_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        cell_rd_reg <= cell_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rate_we)
        begin
            rate_mem[rate_waddr] <= rate_wdata;
        end
        rate_rd_reg <= rate_mem[rate_raddr];
    end

    // control and datapath registers
    gfhs_pkg::state_t state_reg, state_next;
    logic [MA-1:0]    clr_reg, clr_next;
    logic             bank_reg, bank_next;
    logic [CA-1:0]    cell_reg, cell_next;
    logic [SW-1:0]    x_reg, x_next, y_reg, y_next;
    logic [TW-1:0]    tv_reg, tv_next;
    logic [FW-1:0]    fv_reg, fv_next;
    logic [1:0]       mode_reg, mode_next;
    logic [gfhs_pkg::DTS_W-1:0] dts_reg, dts_next;
    logic [gfhs_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic signed [3:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [TW-1:0]    ctr_temp_reg, ctr_temp_next;
    logic [FW-1:0]    ctr_fuel_reg, ctr_fuel_next;
    logic             ctr_on_reg, ctr_on_next;
    logic [RW-1:0]    ctr_rate_reg, ctr_rate_next;
    logic [gfhs_pkg::ACC_W-1:0]  cond_acc_reg, cond_acc_next;
    logic [gfhs_pkg::TERM_W-1:0] rad_acc_reg, rad_acc_next;
    logic             p0_valid_reg, p0_valid_next;
    logic [gfhs_pkg::K_W-1:0] p0_k_reg, p0_k_next;
    logic [18:0]      t0_reg, t0_next;
    logic [FW-1:0]    use_reg, use_next;
    logic [23:0]      ramp_reg, ramp_next;
    logic [gfhs_pkg::CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_status_reg, out_status_next;
    logic [TW-1:0]    out_temp_reg, out_temp_next;
    logic [FW-1:0]    out_fuel_reg, out_fuel_next;
    logic [RW-1:0]    out_rate_reg, out_rate_next;
    logic             out_burn_reg, out_burn_next;
    logic [gfhs_pkg::CNT_W-1:0] out_cells_reg, out_cells_next;

    // shared decode
    logic            cmd_acc, cmd_off_grid, cell_in_grid, cell_copy, cell_last, nbr_last;
    logic [31:0]     dts_full;
    logic signed [6:0] nx_s, ny_s;
    logic            nbr_in;
    logic [3:0]      adx4, ady4;
    logic [2:0]      adx, ady;
    logic [gfhs_pkg::K_W-1:0] nbr_k;
    gfhs_pkg::term_in_t  tin;
    gfhs_pkg::term_out_t tout;
    logic [gfhs_pkg::ACC_W-1:0] gain_sum;
    logic [gfhs_pkg::CAP_W-1:0] gain;
    logic [35:0]     use_full;
    logic [39:0]     ramp_full;
    logic [24:0]     t_burn, t_fin;
    logic [18:0]     dec;
    logic            on_fin;
    logic [FW-1:0]   f_fin;

    assign cmd.ready    = (state_reg == gfhs_pkg::ST_IDLE) && (!out_valid_reg || res.ready);
    assign cmd_acc      = cmd.valid && cmd.ready;
    assign cmd_off_grid = ({1'b0, cmd.cell_x} >= cols_sat) || ({1'b0, cmd.cell_y} >= rows_sat);
    assign cell_in_grid = ({1'b0, cell_reg[SW-1:0]} < cols_sat)
                       && ({1'b0, cell_reg[CA-1:SW]} < rows_sat);
    assign cell_copy    = !cell_in_grid
                       || (cell_rd_reg.fuel == '0 && cell_rd_reg.temp <= gfhs_pkg::T_SKIP);
    assign cell_last    = &cell_reg;
    assign nbr_last     = (dx_reg == gfhs_pkg::D_HI) && (dy_reg == gfhs_pkg::D_HI);
    assign dts_full     = cmd.time_step * time_scale_reg;

    assign nx_s   = $signed({2'b00, cell_reg[SW-1:0]}) + 7'(dx_reg);
    assign ny_s   = $signed({2'b00, cell_reg[CA-1:SW]}) + 7'(dy_reg);
    assign nbr_in = !nx_s[6] && !ny_s[6] && (nx_s[5:0] < cols_sat) && (ny_s[5:0] < rows_sat)
                 && !(dx_reg == 4'sd0 && dy_reg == 4'sd0);
    assign adx4   = dx_reg[3] ? (~dx_reg + 4'd1) : dx_reg;
    assign ady4   = dy_reg[3] ? (~dy_reg + 4'd1) : dy_reg;
    assign adx    = adx4[2:0];
    assign ady    = ady4[2:0];
    assign nbr_k  = ({3'b000, adx} * {3'b000, adx}) + ({3'b000, ady} * {3'b000, ady});

    assign tin.valid   = p0_valid_reg && (cell_rd_reg.temp > ctr_temp_reg);
    assign tin.burning = cell_rd_reg.burning;
    assign tin.tn      = cell_rd_reg.temp;
    assign tin.diff    = cell_rd_reg.temp - ctr_temp_reg;
    assign tin.k       = p0_k_reg;

    gfhs_term u_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .tin       (tin),
        .cond_gain (cond_gain_reg),
        .rad_gain  (rad_gain_reg),
        .dts       (dts_reg),
        .tout      (tout)
    );

    // finish arithmetic
    assign gain_sum  = cond_acc_reg + gfhs_pkg::ACC_W'(rad_acc_reg);
    assign gain      = (gain_sum > gfhs_pkg::ACC_W'(cap_reg)) ? cap_reg
                                                             : gain_sum[gfhs_pkg::CAP_W-1:0];
    assign use_full  = 36'(ctr_rate_reg) * 36'(dts_reg);
    assign ramp_full = 40'(burn_ramp_reg) * 40'(dts_reg);
    assign dec       = 19'(dts_reg[gfhs_pkg::DTS_W-1:11]);
    assign t_burn    = 25'(t0_reg) + 25'(ramp_reg);

    always_comb
    begin
        if (ctr_on_reg)
        begin
            t_fin = (t_burn > gfhs_pkg::T_BURN_MAX) ? gfhs_pkg::T_BURN_MAX : t_burn;
            if (ctr_fuel_reg <= use_reg)
            begin
                f_fin  = '0;
                on_fin = 1'b0;
            end
            else
            begin
                f_fin  = ctr_fuel_reg - use_reg;
                on_fin = 1'b1;
            end
        end
        else
        begin
            if (t0_reg > 19'(gfhs_pkg::T_AMBIENT))
            begin
                t_fin = (t0_reg > dec) ? 25'(t0_reg - dec) : 25'd0;
            end
            else
            begin
                t_fin = 25'(t0_reg);
            end
            f_fin  = ctr_fuel_reg;
            on_fin = (ctr_temp_reg > gfhs_pkg::T_IGNITE) && (ctr_fuel_reg != '0);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gfhs_pkg::ST_CLEAR:
                if (&clr_reg) state_next = gfhs_pkg::ST_IDLE;
            gfhs_pkg::ST_IDLE:
                if (cmd_acc)
                begin
                    if (cmd.mode == gfhs_pkg::MODE_STEP)
                        state_next = gfhs_pkg::ST_STEP_CTR;
                    else if (!cmd_off_grid && cmd.mode != gfhs_pkg::MODE_WRITE)
                        state_next = gfhs_pkg::ST_CELL_OP;
                end
            gfhs_pkg::ST_CELL_OP:
                state_next = gfhs_pkg::ST_IDLE;
            gfhs_pkg::ST_STEP_CTR:
                state_next = gfhs_pkg::ST_STEP_EVAL;
            gfhs_pkg::ST_STEP_EVAL:
                if (!cell_copy)
                    state_next = gfhs_pkg::ST_STEP_NBR;
                else if (cell_last)
                    state_next = gfhs_pkg::ST_STEP_DONE;
                else
                    state_next = gfhs_pkg::ST_STEP_CTR;
            gfhs_pkg::ST_STEP_NBR:
                if (nbr_last) state_next = gfhs_pkg::ST_STEP_DRAIN;
            gfhs_pkg::ST_STEP_DRAIN:
                if (!p0_valid_reg && !tout.busy) state_next = gfhs_pkg::ST_STEP_FIN1;
            gfhs_pkg::ST_STEP_FIN1:
                state_next = gfhs_pkg::ST_STEP_FIN2;
            gfhs_pkg::ST_STEP_FIN2:
                state_next = cell_last ? gfhs_pkg::ST_STEP_DONE : gfhs_pkg::ST_STEP_CTR;
            gfhs_pkg::ST_STEP_DONE:
                state_next = gfhs_pkg::ST_IDLE;
            default:
                state_next = gfhs_pkg::ST_IDLE;
        endcase
    end

    // datapath, store access and result
    always_comb
    begin
        clr_next        = clr_reg;
        bank_next       = bank_reg;
        cell_next       = cell_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        tv_next         = tv_reg;
        fv_next         = fv_reg;
        mode_next       = mode_reg;
        dts_next        = dts_reg;
        cap_next        = cap_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        ctr_temp_next   = ctr_temp_reg;
        ctr_fuel_next   = ctr_fuel_reg;
        ctr_on_next     = ctr_on_reg;
        ctr_rate_next   = ctr_rate_reg;
        cond_acc_next   = cond_acc_reg;
        rad_acc_next    = rad_acc_reg;
        p0_valid_next   = 1'b0;
        p0_k_next       = nbr_k;
        t0_next         = t0_reg;
        use_next        = use_reg;
        ramp_next       = ramp_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_status_next = out_status_reg;
        out_temp_next   = out_temp_reg;
        out_fuel_next   = out_fuel_reg;
        out_rate_next   = out_rate_reg;
        out_burn_next   = out_burn_reg;
        out_cells_next  = out_cells_reg;
        mem_we          = 1'b0;
        mem_waddr       = {~bank_reg, cell_reg};
        mem_wdata       = cell_rd_reg;
        mem_raddr       = {bank_reg, cell_reg};
        rate_we         = 1'b0;
        rate_waddr      = {y_reg, x_reg};
        rate_wdata      = cmd.burn_rate_value;
        rate_raddr      = cell_reg;

        if (tout.valid)
        begin
            cond_acc_next = cond_acc_reg + gfhs_pkg::ACC_W'(tout.cond);
            if (tout.rad > rad_acc_reg) rad_acc_next = tout.rad;
        end

        unique case (state_reg)
            gfhs_pkg::ST_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = clr_reg;
                mem_wdata  = '{burning: 1'b0, fuel: '0, temp: gfhs_pkg::T_AMBIENT};
                rate_we    = 1'b1;
                rate_waddr = clr_reg[CA-1:0];
                rate_wdata = '0;
                clr_next   = clr_reg + MA'(1);
            end
            gfhs_pkg::ST_IDLE:
            begin
                mem_raddr  = {bank_reg, cmd.cell_y, cmd.cell_x};
                rate_raddr = {cmd.cell_y, cmd.cell_x};
                if (cmd_acc)
                begin
                    x_next    = cmd.cell_x;
                    y_next    = cmd.cell_y;
                    tv_next   = cmd.temperature_value;
                    fv_next   = cmd.fuel_value;
                    mode_next = cmd.mode;
                    dts_next  = dts_full[31:8];
                    if (cmd.mode == gfhs_pkg::MODE_STEP)
                    begin
                        cell_next  = '0;
                        count_next = '0;
                    end
                    else if (cmd_off_grid || cmd.mode == gfhs_pkg::MODE_WRITE)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = cmd_off_grid;
                        out_temp_next   = '0;
                        out_fuel_next   = '0;
                        out_rate_next   = '0;
                        out_burn_next   = 1'b0;
                        out_cells_next  = '0;
                        if (!cmd_off_grid)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = {bank_reg, cmd.cell_y, cmd.cell_x};
                            mem_wdata  = '{burning: cmd.burning_value,
                                           fuel: cmd.fuel_value,
                                           temp: cmd.temperature_value};
                            rate_we    = 1'b1;
                            rate_waddr = {cmd.cell_y, cmd.cell_x};
                        end
                    end
                end
            end
            gfhs_pkg::ST_CELL_OP:
            begin
                out_valid_next  = 1'b1;
                out_status_next = 1'b0;
                out_cells_next  = '0;
                if (mode_reg == gfhs_pkg::MODE_READ)
                begin
                    out_temp_next = cell_rd_reg.temp;
                    out_fuel_next = cell_rd_reg.fuel;
                    out_rate_next = rate_rd_reg;
                    out_burn_next = cell_rd_reg.burning;
                end
                else
                begin
                    out_temp_next = '0;
                    out_fuel_next = '0;
                    out_rate_next = '0;
                    out_burn_next = 1'b0;
                    mem_we        = 1'b1;
                    mem_waddr     = {bank_reg, y_reg, x_reg};
                    mem_wdata     = '{burning: 1'b1,
                                      fuel: (cell_rd_reg.fuel == '0) ? fv_reg : cell_rd_reg.fuel,
                                      temp: tv_reg};
                end
            end
            gfhs_pkg::ST_STEP_CTR:
            begin
                cap_next = gfhs_pkg::CAP_W'(dts_reg) * gfhs_pkg::CAP_W'(gfhs_pkg::CAP_MUL);
            end
            gfhs_pkg::ST_STEP_EVAL:
            begin
                if (cell_copy)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = cell_rd_reg;
                    if (cell_in_grid && cell_rd_reg.burning)
                        count_next = count_reg + gfhs_pkg::CNT_W'(1);
                    cell_next = cell_reg + CA'(1);
                end
                else
                begin
                    ctr_temp_next = cell_rd_reg.temp;
                    ctr_fuel_next = cell_rd_reg.fuel;
                    ctr_on_next   = cell_rd_reg.burning;
                    ctr_rate_next = rate_rd_reg;
                    cond_acc_next = '0;
                    rad_acc_next  = '0;
                    dx_next       = gfhs_pkg::D_LO;
                    dy_next       = gfhs_pkg::D_LO;
                end
            end
            gfhs_pkg::ST_STEP_NBR:
            begin
                mem_raddr     = {bank_reg, ny_s[SW-1:0], nx_s[SW-1:0]};
                p0_valid_next = nbr_in;
                if (dx_reg == gfhs_pkg::D_HI)
                begin
                    dx_next = gfhs_pkg::D_LO;
                    dy_next = dy_reg + 4'sd1;
                end
                else
                begin
                    dx_next = dx_reg + 4'sd1;
                end
            end
            gfhs_pkg::ST_STEP_DRAIN: ;
            gfhs_pkg::ST_STEP_FIN1:
            begin
                t0_next   = 19'(ctr_temp_reg) + 19'(gain[gfhs_pkg::CAP_W-1:16]);
                use_next  = use_full[35:20];
                ramp_next = ramp_full[39:16];
            end
            gfhs_pkg::ST_STEP_FIN2:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{burning: on_fin,
                              fuel: f_fin,
                              temp: (t_fin > 25'(16'hFFFF)) ? 16'hFFFF : t_fin[TW-1:0]};
                if (on_fin) count_next = count_reg + gfhs_pkg::CNT_W'(1);
                cell_next = cell_reg + CA'(1);
            end
            gfhs_pkg::ST_STEP_DONE:
            begin
                bank_next       = ~bank_reg;
                out_valid_next  = 1'b1;
                out_status_next = 1'b0;
                out_temp_next   = '0;
                out_fuel_next   = '0;
                out_rate_next   = '0;
                out_burn_next   = 1'b0;
                out_cells_next  = count_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gfhs_pkg::ST_CLEAR;
            clr_reg       <= '0;
            bank_reg      <= 1'b0;
            p0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            bank_reg      <= bank_next;
            p0_valid_reg  <= p0_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg       <= cell_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        tv_reg         <= tv_next;
        fv_reg         <= fv_next;
        mode_reg       <= mode_next;
        dts_reg        <= dts_next;
        cap_reg        <= cap_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        ctr_temp_reg   <= ctr_temp_next;
        ctr_fuel_reg   <= ctr_fuel_next;
        ctr_on_reg     <= ctr_on_next;
        ctr_rate_reg   <= ctr_rate_next;
        cond_acc_reg   <= cond_acc_next;
        rad_acc_reg    <= rad_acc_next;
        p0_k_reg       <= p0_k_next;
        t0_reg         <= t0_next;
        use_reg        <= use_next;
        ramp_reg       <= ramp_next;
        count_reg      <= count_next;
        out_status_reg <= out_status_next;
        out_temp_reg   <= out_temp_next;
        out_fuel_reg   <= out_fuel_next;
        out_rate_reg   <= out_rate_next;
        out_burn_reg   <= out_burn_next;
        out_cells_reg  <= out_cells_next;
    end

    assign res.valid           = out_valid_reg;
    assign res.status          = out_status_reg;
    assign res.temperature_out = out_temp_reg;
    assign res.fuel_out        = out_fuel_reg;
    assign res.burn_rate_out   = out_rate_reg;
    assign res.burning_out     = out_burn_reg;
    assign res.burning_cells   = out_cells_reg;

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gfhs_pkg::ST_CLEAR) |-> !out_valid_reg)
        else $error("result raised during clearing pass");

    a_no_write_in_nbr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gfhs_pkg::ST_STEP_NBR || state_reg == gfhs_pkg::ST_STEP_DRAIN)
        |-> !mem_we)
        else $error("store written during neighbor scan");

    a_term_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tout.valid |-> (state_reg == gfhs_pkg::ST_STEP_NBR
                     || state_reg == gfhs_pkg::ST_STEP_DRAIN))
        else $error("neighbor term outside scan");

    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gfhs_pkg::ST_STEP_DONE) |=> (bank_reg != $past(bank_reg)))
        else $error("bank not swapped after step");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for grid_fire_heat_spread_step.
// Uses gfhs_pkg, gfhs_cmd_if and gfhs_res_if; predicts each result word with an
// in-class model of the cell store and compares it with the block's output.
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic        status;
        logic [15:0] temp;
        logic [15:0] fuel;
        logic [11:0] rate;
        logic        burning;
        logic [10:0] count;
    } fire_result_t;

    class fire_grid_scoreboard;
        bit [15:0]    temp_mem [2048];
        bit [15:0]    fuel_mem [2048];
        bit [11:0]    rate_mem [1024];
        bit           burn_mem [2048];
        bit           bank;
        bit [15:0]    cond_gain, rad_gain, ramp, tscale;
        bit [5:0]     cols, rows;
        fire_result_t pending_q [$];
        int           errors;

        function new();
            for (int i = 0; i < 2048; i++)
            begin
                temp_mem[i] = 320;
                fuel_mem[i] = 0;
                burn_mem[i] = 0;
            end
            for (int i = 0; i < 1024; i++)
                rate_mem[i] = 0;
            bank = 0;
            cond_gain = 655;
            rad_gain = 3932;
            ramp = 2400;
            tscale = 128;
            cols = 10;
            rows = 10;
            errors = 0;
        endfunction

        function void set_reg(gfhs_pkg::cfg_idx_t idx, bit [15:0] val);
            case (idx)
                gfhs_pkg::CFG_COND_GAIN:  cond_gain = val;
                gfhs_pkg::CFG_RAD_GAIN:   rad_gain = val;
                gfhs_pkg::CFG_BURN_RAMP:  ramp = val;
                gfhs_pkg::CFG_TIME_SCALE: tscale = val;
                gfhs_pkg::CFG_COLUMNS:    cols = val[5:0];
                gfhs_pkg::CFG_ROWS:       rows = val[5:0];
                default:        ;
            endcase
        endfunction

        function int used(bit [5:0] v);
            return (v > 32) ? 32 : v;
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned r, c;
            r = 0;
            for (int b = 20; b >= 0; b--)
            begin
                c = r | (64'd1 << b);
                if (c * c <= v)
                    r = c;
            end
            return r;
        endfunction

        function int unsigned spread_heat(longint unsigned dts);
            int unsigned cur, nxt, a, b, k, cnt;
            int nc, nr, nx, ny;
            longint unsigned tc, fc, tn, cond, rad, gain, t, term, burn_use, dec;
            bit on;
            cur = bank * 1024;
            nxt = (bank ^ 1) * 1024;
            nc = used(cols);
            nr = used(rows);
            cnt = 0;
            for (int i = 0; i < 1024; i++)
            begin
                temp_mem[nxt + i] = temp_mem[cur + i];
                fuel_mem[nxt + i] = fuel_mem[cur + i];
                burn_mem[nxt + i] = burn_mem[cur + i];
            end
            for (int y = 0; y < nr; y++)
                for (int x = 0; x < nc; x++)
                begin
                    a = y * 32 + x;
                    tc = temp_mem[cur + a];
                    fc = fuel_mem[cur + a];
                    on = burn_mem[cur + a];
                    if (fc == 0 && tc <= 321)
                        continue;
                    cond = 0;
                    rad = 0;
                    for (int dy = -4; dy <= 4; dy++)
                        for (int dx = -4; dx <= 4; dx++)
                        begin
                            nx = x + dx;
                            ny = y + dy;
                            if (dx == 0 && dy == 0)
                                continue;
                            if (nx < 0 || ny < 0 || nx >= nc || ny >= nr)
                                continue;
                            b = ny * 32 + nx;
                            tn = temp_mem[cur + b];
                            if (tn <= tc)
                                continue;
                            k = dx * dx + dy * dy;
                            term = (((tn - tc) * root((64'd1 << 32) / k) * cond_gain) >> 16)
                                   * dts >> 16;
                            cond += term;
                            if (burn_mem[cur + b])
                            begin
                                term = ((tn * (65536 / k) * rad_gain) >> 16) * dts >> 16;
                                if (term > rad)
                                    rad = term;
                            end
                        end
                    gain = cond + rad;
                    if (gain > 800 * dts)
                        gain = 800 * dts;
                    t = tc + (gain >> 16);
                    if (on)
                    begin
                        burn_use = (rate_mem[a] * dts) >> 20;
                        t += (ramp * dts) >> 16;
                        if (t > 12800)
                            t = 12800;
                        if (fc <= burn_use)
                        begin
                            fc = 0;
                            on = 0;
                        end
                        else
                            fc = fc - burn_use;
                    end
                    else
                    begin
                        if (t > 320)
                        begin
                            dec = (32 * dts) >> 16;
                            t = (t > dec) ? t - dec : 0;
                        end
                        if (temp_mem[cur + a] > 2400 && fuel_mem[cur + a] > 0)
                            on = 1;
                    end
                    if (t > 65535)
                        t = 65535;
                    temp_mem[nxt + a] = t[15:0];
                    fuel_mem[nxt + a] = fc[15:0];
                    burn_mem[nxt + a] = on;
                end
            bank ^= 1;
            for (int y = 0; y < nr; y++)
                for (int x = 0; x < nc; x++)
                    cnt += burn_mem[nxt + y * 32 + x];
            return cnt;
        endfunction

        function void note_word(gfhs_pkg::mode_t m, bit [4:0] x, bit [4:0] y, bit [15:0] tv,
                                bit [15:0] fv, bit [11:0] rv, bit bv, bit [15:0] ts);
            fire_result_t r;
            int unsigned base, a;
            r = '{default: 0};
            base = bank * 1024;
            a = y * 32 + x;
            if (m == gfhs_pkg::MODE_STEP)
                r.count = spread_heat((longint'(ts) * tscale) >> 8);
            else if (x >= used(cols) || y >= used(rows))
                r.status = 1;
            else if (m == gfhs_pkg::MODE_WRITE)
            begin
                temp_mem[base + a] = tv;
                fuel_mem[base + a] = fv;
                rate_mem[a] = rv;
                burn_mem[base + a] = bv;
            end
            else if (m == gfhs_pkg::MODE_READ)
            begin
                r.temp = temp_mem[base + a];
                r.fuel = fuel_mem[base + a];
                r.rate = rate_mem[a];
                r.burning = burn_mem[base + a];
            end
            else
            begin
                temp_mem[base + a] = tv;
                burn_mem[base + a] = 1;
                if (fuel_mem[base + a] == 0)
                    fuel_mem[base + a] = fv;
            end
            pending_q.push_back(r);
        endfunction

        function void check_word(fire_result_t got);
            fire_result_t e;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result word");
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.status !== e.status)
            begin
                $error("status exp %0d got %0d", e.status, got.status);
                errors++;
            end
            if (got.temp !== e.temp)
            begin
                $error("temperature_out exp %0d got %0d", e.temp, got.temp);
                errors++;
            end
            if (got.fuel !== e.fuel)
            begin
                $error("fuel_out exp %0d got %0d", e.fuel, got.fuel);
                errors++;
            end
            if (got.rate !== e.rate)
            begin
                $error("burn_rate_out exp %0d got %0d", e.rate, got.rate);
                errors++;
            end
            if (got.burning !== e.burning)
            begin
                $error("burning_out exp %0d got %0d", e.burning, got.burning);
                errors++;
            end
            if (got.count !== e.count)
            begin
                $error("burning_cells exp %0d got %0d", e.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write;
    logic [gfhs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gfhs_pkg::CFG_W-1:0]     cfg_data;
    int                             idle_pct;
    int                             stall_pct;
    fire_grid_scoreboard            sb;

    gfhs_cmd_if cmd ();
    gfhs_res_if res ();

    grid_fire_heat_spread_step u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd.source),
        .res       (res.sink)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
        res.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
        if (rst_n && res.valid && res.ready)
            sb.check_word('{res.status, res.temperature_out, res.fuel_out,
                            res.burn_rate_out, res.burning_out, res.burning_cells});

    task automatic send_word(gfhs_pkg::mode_t m, bit [4:0] x, bit [4:0] y, bit [15:0] tv,
                             bit [15:0] fv, bit [11:0] rv, bit bv, bit [15:0] ts);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.mode <= m;
        cmd.cell_x <= x;
        cmd.cell_y <= y;
        cmd.temperature_value <= tv;
        cmd.fuel_value <= fv;
        cmd.burn_rate_value <= rv;
        cmd.burning_value <= bv;
        cmd.time_step <= ts;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        sb.note_word(m, x, y, tv, fv, rv, bv, ts);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(gfhs_pkg::cfg_idx_t idx, bit [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic load_regs(bit [15:0] cg, bit [15:0] rg, bit [15:0] rp, bit [15:0] ts,
                             bit [5:0] nc, bit [5:0] nr);
        write_reg(gfhs_pkg::CFG_COND_GAIN, cg);
        write_reg(gfhs_pkg::CFG_RAD_GAIN, rg);
        write_reg(gfhs_pkg::CFG_BURN_RAMP, rp);
        write_reg(gfhs_pkg::CFG_TIME_SCALE, ts);
        write_reg(gfhs_pkg::CFG_COLUMNS, nc);
        write_reg(gfhs_pkg::CFG_ROWS, nr);
    endtask

    function automatic bit [4:0] pick_coord(int lim);
        if (lim == 0)
            return $urandom_range(31);
        return $urandom_range(((lim > 32) ? 32 : lim) - 1);
    endfunction

    function automatic bit [15:0] pick_temp();
        case ($urandom_range(3))
            0:       return $urandom_range(300, 330);
            1:       return $urandom_range(2300, 2500);
            2:       return $urandom_range(65535);
            default: return $urandom_range(3000, 13000);
        endcase
    endfunction

    task automatic fire_sequence(ref int sent);
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            send_word(gfhs_pkg::MODE_WRITE, pick_coord(sb.cols), pick_coord(sb.rows),
                      pick_temp(), ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom),
                      12'($urandom), 1'($urandom), 16'($urandom));
            sent++;
        end
        if ($urandom_range(1))
        begin
            send_word(gfhs_pkg::MODE_IGNITE, pick_coord(sb.cols), pick_coord(sb.rows),
                      pick_temp(), 16'($urandom), 12'($urandom), 1'($urandom),
                      16'($urandom));
            sent++;
        end
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
        begin
            send_word(gfhs_pkg::MODE_STEP, 5'($urandom), 5'($urandom), 16'($urandom),
                      16'($urandom), 12'($urandom), 1'($urandom), 16'($urandom));
            send_word(gfhs_pkg::MODE_READ, pick_coord(sb.cols), pick_coord(sb.rows),
                      16'($urandom), 16'($urandom), 12'($urandom), 1'($urandom),
                      16'($urandom));
            sent += 2;
        end
    endtask

    task automatic random_phase(int n_words);
        int sent;
        sent = 0;
        while (sent < n_words)
        begin
            if ($urandom_range(99) < 65)
                fire_sequence(sent);
            else
            begin
                send_word(gfhs_pkg::mode_t'($urandom_range(3)), 5'($urandom), 5'($urandom),
                          16'($urandom), 16'($urandom), 12'($urandom), 1'($urandom),
                          16'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        #40_000_000;
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        sb = new();
        idle_pct = 0;
        stall_pct = 0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd.valid = 1'b0;
        cmd.mode = gfhs_pkg::MODE_WRITE;
        cmd.cell_x = '0;
        cmd.cell_y = '0;
        cmd.temperature_value = '0;
        cmd.fuel_value = '0;
        cmd.burn_rate_value = '0;
        cmd.burning_value = 1'b0;
        cmd.time_step = '0;
        res.ready = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings (10 x 10 grid)
        send_word(gfhs_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0);
        send_word(gfhs_pkg::MODE_WRITE, 0, 0, 16'hFFFF, 16'hFFFF, 12'hFFF, 1, 0);
        send_word(gfhs_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0);
        send_word(gfhs_pkg::MODE_WRITE, 9, 9, 0, 0, 0, 0, 16'hFFFF);
        send_word(gfhs_pkg::MODE_READ, 9, 9, 0, 0, 0, 0, 0);
        send_word(gfhs_pkg::MODE_WRITE, 10, 0, 1000, 5, 5, 1, 0);
        send_word(gfhs_pkg::MODE_READ, 0, 31, 0, 0, 0, 0, 0);
        send_word(gfhs_pkg::MODE_IGNITE, 31, 31, 4000, 50, 0, 0, 0);
        send_word(gfhs_pkg::MODE_IGNITE, 3, 3, 4000, 100, 0, 0, 0);
        send_word(gfhs_pkg::MODE_IGNITE, 0, 0, 3000, 7, 0, 0, 0);
        send_word(gfhs_pkg::MODE_WRITE, 5, 5, 3000, 500, 100, 0, 0);
        send_word(gfhs_pkg::MODE_WRITE, 6, 6, 321, 0, 0, 0, 0);
        send_word(gfhs_pkg::MODE_WRITE, 7, 7, 2401, 0, 0, 0, 0);
        send_word(gfhs_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 16'hFFFF);
        send_word(gfhs_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0);
        send_word(gfhs_pkg::MODE_READ, 3, 3, 0, 0, 0, 0, 0);
        send_word(gfhs_pkg::MODE_READ, 5, 5, 0, 0, 0, 0, 0);
        send_word(gfhs_pkg::MODE_READ, 6, 6, 0, 0, 0, 0, 0);
        send_word(gfhs_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 16'h8000);
        send_word(gfhs_pkg::MODE_READ, 4, 4, 0, 0, 0, 0, 0);
        send_word(gfhs_pkg::MODE_READ, 7, 7, 0, 0, 0, 0, 0);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32, 32);
                1: load_regs(0, 0, 0, 0, 63, 1);
                2: load_regs(5240, 3932, 2400, 256, 7, 9);
                default: load_regs(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom_range(1024)), $urandom_range(1, 12),
                                   $urandom_range(1, 12));
            endcase
            idle_pct = (p == 1) ? 78 : ((p == 3) ? 24 : 0);
            stall_pct = (p == 2) ? 78 : ((p == 3) ? 24 : 0);
            random_phase(8);
            drain();
            random_phase(8);
            drain();
        end

        write_reg(gfhs_pkg::CFG_COLUMNS, 0);
        for (int i = 0; i < 4; i++)
            send_word(gfhs_pkg::mode_t'($urandom_range(3)), 5'($urandom), 5'($urandom),
                      16'($urandom), 16'($urandom), 12'($urandom), 1'($urandom),
                      16'($urandom));
        drain();
        repeat (50) @(posedge clk);

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

/* sim.f */
rtl/gfhs_pkg.sv
rtl/gfhs_cmd_if.sv
rtl/gfhs_res_if.sv
rtl/gfhs_term.sv
rtl/grid_fire_heat_spread_step.sv
verif/testbench.sv
